/* hw/rtl/stli_pkg.sv */
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants for the sorted-table interpolator
// Controller states, command codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none
package stli_pkg;

   localparam int MaxRows      = 1024;
   localparam int NumColumns   = 4;
   localparam int FractionBits = 16;
   localparam int RowBits      = 10;
   localparam int ColBits      = 2;
   localparam int CountBits    = 11;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_END0,
      ST_END1,
      ST_ENDCMP,
      ST_PROBE,
      ST_PROBE_CMP,
      ST_PAIR0,
      ST_PAIR1,
      ST_DIV,
      ST_MUL0,
      ST_MUL1,
      ST_SUM,
      ST_OUT
   } state_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_RD_FIRST,
      OP_RD_LAST,
      OP_ENDCMP,
      OP_RD_MID,
      OP_PROBE,
      OP_RD_LO,
      OP_RD_HI,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL0,
      OP_MUL1,
      OP_SUM
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic bad_col;
      logic clamp_hit;
      logic search_done;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

/* hw/rtl/stli_datapath.sv */
// ----------------------------------------------------------------------------
// stli_datapath: table memories, binary search, divider and blend
// Holds key and value memories, probe pointers, a radix-2 divider and the
// two-product weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none
module stli_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_transfer,
   input  wire                  req_command,
   input  wire [9:0]            req_row_index,
   input  wire [1:0]            req_column,
   input  wire [31:0]           req_key,
   input  wire signed [31:0]    req_value,
   input  wire [10:0]           csr_rows,
   input  stli_pkg::cmd_type    cmd,
   output stli_pkg::status_type status,
   output logic signed [31:0]   res_value,
   output logic                 res_clamped
);

   localparam int FB = stli_pkg::FractionBits;

   // memories
   logic [31:0] key_mem   [stli_pkg::MaxRows];
   logic [31:0] value_mem [stli_pkg::MaxRows * stli_pkg::NumColumns];
   logic [31:0] key_rd_ff;
   logic [31:0] val_rd_ff;

   logic [9:0]  key_addr;
   logic [11:0] val_addr;

   // query context
   logic [31:0] qkey_ff;
   logic [1:0]  qcol_ff;
   logic        is_load_ff;
   logic [10:0] rows_ff;
   logic [10:0] first_ff, first_in;
   logic [10:0] count_ff, count_in;
   logic [31:0] k0_ff, ka_ff;
   logic signed [31:0] v0_ff, va_ff;
   logic [10:0] hi_sel;

   logic [10:0] half;
   logic [10:0] mid;

   always_comb begin
      half = count_ff >> 1;
      mid  = first_ff + half;
      hi_sel = first_ff;
      if (hi_sel < 11'd1) hi_sel = 11'd1;
      if (hi_sel > rows_ff - 11'd1) hi_sel = rows_ff - 11'd1;
   end

   // memory address select
   always_comb begin
      key_addr = 10'd0;
      case (cmd.op)
         stli_pkg::OP_RD_LAST: key_addr = 10'(rows_ff - 11'd1);
         stli_pkg::OP_RD_MID:  key_addr = mid[9:0];
         stli_pkg::OP_RD_LO:   key_addr = 10'(hi_sel - 11'd1);
         stli_pkg::OP_RD_HI:   key_addr = hi_sel[9:0];
         default:              key_addr = 10'd0;
      endcase
      val_addr = {key_addr, qcol_ff};
   end

   // memory ports: one write per load, one registered read each
   always_ff @(posedge clock) begin
      if (req_transfer && req_command == stli_pkg::CMD_LOAD) begin
         key_mem[req_row_index] <= req_key;
         value_mem[{req_row_index, req_column}] <= req_value;
      end
      key_rd_ff <= key_mem[key_addr];
      val_rd_ff <= value_mem[val_addr];
   end

   // divider and products
   logic [FB:0]   frac_ff;
   logic [32:0]   rem_ff;
   logic [31:0]   dvs_ff;
   logic [4:0]    dcnt_ff;
   logic          fzero_ff, fone_ff;
   logic signed [49:0] p0_ff, p1_ff;
   logic signed [50:0] sum;
   logic [33:0]   rem_sh;
   logic [FB:0]   wlo;

   always_comb begin
      rem_sh = {rem_ff, 1'b0};
      wlo = (17'(1) << FB) - frac_ff;
      sum = 51'(p0_ff) + 51'(p1_ff);
   end

   // search, divide and blend registers
   always_ff @(posedge clock) begin
      if (reset) begin
         is_load_ff <= 1'b0;
      end else begin
         case (cmd.op)
            stli_pkg::OP_CAPTURE: begin
               is_load_ff <= (req_command == stli_pkg::CMD_LOAD);
               qkey_ff    <= req_key;
               qcol_ff    <= req_column;
               rows_ff    <= (csr_rows < 11'd2) ? 11'd2 :
                             (csr_rows > 11'(stli_pkg::MaxRows)) ?
                             11'(stli_pkg::MaxRows) : csr_rows;
            end
            stli_pkg::OP_RD_LAST: begin
               k0_ff <= key_rd_ff;
               v0_ff <= val_rd_ff;
            end
            stli_pkg::OP_ENDCMP: begin
               first_ff <= 11'd0;
               count_ff <= rows_ff;
               if (qkey_ff <= k0_ff) begin
                  res_value   <= v0_ff;
                  res_clamped <= 1'b1;
               end else if (qkey_ff >= key_rd_ff) begin
                  res_value   <= val_rd_ff;
                  res_clamped <= 1'b1;
               end else begin
                  res_clamped <= 1'b0;
               end
            end
            stli_pkg::OP_PROBE: begin
               first_ff <= first_in;
               count_ff <= count_in;
            end
            stli_pkg::OP_RD_HI: begin
               ka_ff <= key_rd_ff;
               va_ff <= val_rd_ff;
            end
            stli_pkg::OP_DIV_INIT: begin
               fzero_ff <= (key_rd_ff <= ka_ff) || (qkey_ff <= ka_ff);
               fone_ff  <= (qkey_ff >= key_rd_ff);
               rem_ff   <= {1'b0, qkey_ff - ka_ff};
               dvs_ff   <= key_rd_ff - ka_ff;
               v0_ff    <= val_rd_ff;
               frac_ff  <= '0;
               dcnt_ff  <= 5'(FB);
            end
            stli_pkg::OP_DIV_STEP: begin
               if (34'(dvs_ff) <= rem_sh) begin
                  rem_ff  <= 33'(rem_sh - 34'(dvs_ff));
                  frac_ff <= {frac_ff[FB-1:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh[32:0];
                  frac_ff <= {frac_ff[FB-1:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 5'd1;
            end
            stli_pkg::OP_MUL0: begin
               if (fzero_ff)     frac_ff <= '0;
               else if (fone_ff) frac_ff <= 17'(1) << FB;
            end
            stli_pkg::OP_MUL1: begin
               p0_ff <= 50'($signed({1'b0, wlo}) * va_ff);
               p1_ff <= 50'($signed({1'b0, frac_ff}) * v0_ff);
            end
            stli_pkg::OP_SUM: res_value <= 32'(sum >>> FB);
            default: ;
         endcase
         if (cmd.op == stli_pkg::OP_CAPTURE && req_column >= 2'(stli_pkg::NumColumns - 1)
             && 3'(req_column) >= 3'(stli_pkg::NumColumns)) begin
            res_value <= '0;
         end
      end
   end

   always_comb begin
      first_in = first_ff;
      count_in = half;
      if (key_rd_ff < qkey_ff) begin
         first_in = mid + 11'd1;
         count_in = count_ff - half - 11'd1;
      end
   end

   assign status.is_load     = is_load_ff;
   assign status.bad_col     = 1'b0;
   assign status.clamp_hit   = res_clamped;
   assign status.search_done = (count_ff == 11'd0);
   assign status.div_done    = (dcnt_ff == 5'd0);

endmodule
`default_nettype wire

/* hw/rtl/stli_ctrl.sv */
// ----------------------------------------------------------------------------
// stli_ctrl: sequencer for loads and queries
// Steps the datapath through end checks, search probes, division and blend.
// ----------------------------------------------------------------------------
`default_nettype none
module stli_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 csr_ready,
   input  stli_pkg::status_type status,
   output stli_pkg::cmd_type    cmd
);

   stli_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= stli_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = stli_pkg::OP_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         stli_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = stli_pkg::OP_CAPTURE;
               state_in = stli_pkg::ST_END0;
            end
         end
         stli_pkg::ST_END0: begin
            if (status.is_load) state_in = stli_pkg::ST_IDLE;
            else begin
               cmd.op   = stli_pkg::OP_RD_FIRST;
               state_in = stli_pkg::ST_END1;
            end
         end
         stli_pkg::ST_END1: begin
            cmd.op   = stli_pkg::OP_RD_LAST;
            state_in = stli_pkg::ST_ENDCMP;
         end
         stli_pkg::ST_ENDCMP: begin
            cmd.op   = stli_pkg::OP_ENDCMP;
            state_in = stli_pkg::ST_PROBE;
         end
         stli_pkg::ST_PROBE: begin
            if (status.clamp_hit) state_in = stli_pkg::ST_OUT;
            else if (status.search_done) begin
               cmd.op   = stli_pkg::OP_RD_LO;
               state_in = stli_pkg::ST_PAIR0;
            end else begin
               cmd.op   = stli_pkg::OP_RD_MID;
               state_in = stli_pkg::ST_PROBE_CMP;
            end
         end
         stli_pkg::ST_PROBE_CMP: begin
            cmd.op   = stli_pkg::OP_PROBE;
            state_in = stli_pkg::ST_PROBE;
         end
         stli_pkg::ST_PAIR0: begin
            cmd.op   = stli_pkg::OP_RD_HI;
            state_in = stli_pkg::ST_PAIR1;
         end
         stli_pkg::ST_PAIR1: begin
            cmd.op   = stli_pkg::OP_DIV_INIT;
            state_in = stli_pkg::ST_DIV;
         end
         stli_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.op   = stli_pkg::OP_MUL0;
               state_in = stli_pkg::ST_MUL1;
            end else cmd.op = stli_pkg::OP_DIV_STEP;
         end
         stli_pkg::ST_MUL1: begin
            cmd.op   = stli_pkg::OP_MUL1;
            state_in = stli_pkg::ST_SUM;
         end
         stli_pkg::ST_SUM: begin
            cmd.op   = stli_pkg::OP_SUM;
            state_in = stli_pkg::ST_OUT;
         end
         stli_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = stli_pkg::ST_IDLE;
         end
         default: state_in = stli_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/sorted_table_linear_interpolator.sv */
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: piecewise linear table lookup
// A load writes the key and value memories and returns no result. A query
// that is clamped at an end of the table skips the search; otherwise it
// runs a binary search, each probe using the single key memory read port,
// then the radix-2 divider forms the fraction bit by bit, then multiply and
// sum. A stalled result holds the block until it is taken.
// One transaction is in flight at a time; the result is held until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_table_linear_interpolator (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_command,
   input  wire [9:0]         req_row_index,
   input  wire [1:0]         req_column,
   input  wire [31:0]        req_key,
   input  wire signed [31:0] req_value,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic              rsp_clamped,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [10:0]        csr_data
);

   stli_pkg::cmd_type    cmd;
   stli_pkg::status_type status;
   logic [10:0] rows_ff;
   logic        req_transfer;

   assign req_transfer = req_valid && !req_stall;

   // row count register
   always_ff @(posedge clock) begin
      if (reset) rows_ff <= 11'd1024;
      else if (csr_valid && csr_ready) rows_ff <= csr_data;
   end

   stli_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .csr_ready, .status, .cmd
   );

   stli_datapath u_dp (
      .clock, .reset, .req_transfer, .req_command, .req_row_index,
      .req_column, .req_key, .req_value, .csr_rows(rows_ff), .cmd, .status,
      .res_value(rsp_result), .res_clamped(rsp_clamped)
   );

   // a result never appears while a new transaction is accepted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept during result");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("result changed");
   // configuration only when idle
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("cfg while busy");

endmodule
`default_nettype wire
